FILE: design/pem_pkg.sv
package pem_pkg;

  // geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [WIDTH_W-1:0]   WIDTH_RESET      = 11'd1024;
  localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET     = 13'd1024;

  // datapath widths
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 10;   // sum of three pixels
  localparam int GRAD_W = 11;   // signed gradient
  localparam int ABS_W  = 10;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int RAD_W  = SQ_W + 1;
  localparam int ROOT_W = 8;
  localparam int STEP_W = $clog2(ROOT_W);
  localparam logic [ROOT_W-1:0] EDGE_MAX = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic shift;    // new column in, gradients captured
    logic square;   // capture squared gradients
  } grad_ctl_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] value;
  } root_res_t;

endpackage

FILE: design/pem_line_ram.sv
module pem_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pem_grad.sv
module pem_grad import pem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  grad_ctl_t        ctl,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] bot,
  output logic [SQ_W-1:0]  sq_x,
  output logic [SQ_W-1:0]  sq_y
);

  // left column and center column, top/mid/bottom
  logic [PIX_W-1:0] lt_r, lm_r, lb_r, ct_r, cm_r, cb_r;
  logic [ABS_W-1:0] ax_r, ay_r;
  logic [SQ_W-1:0]  sq_x_r, sq_y_r;

  logic [SUM_W-1:0]        sum_r, sum_l, sum_t, sum_b;
  logic signed [GRAD_W-1:0] gx, gy, gx_abs, gy_abs;

  always_comb begin
    sum_r  = SUM_W'(top) + SUM_W'(mid) + SUM_W'(bot);
    sum_l  = SUM_W'(lt_r) + SUM_W'(lm_r) + SUM_W'(lb_r);
    sum_t  = SUM_W'(lt_r) + SUM_W'(ct_r) + SUM_W'(top);
    sum_b  = SUM_W'(lb_r) + SUM_W'(cb_r) + SUM_W'(bot);
    gx     = GRAD_W'(sum_r) - GRAD_W'(sum_l);
    gy     = GRAD_W'(sum_t) - GRAD_W'(sum_b);
    gx_abs = gx[GRAD_W-1] ? -gx : gx;
    gy_abs = gy[GRAD_W-1] ? -gy : gy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= '0;
      lm_r <= '0;
      lb_r <= '0;
      ct_r <= '0;
      cm_r <= '0;
      cb_r <= '0;
    end else if (ctl.shift) begin
      lt_r <= ct_r;
      lm_r <= cm_r;
      lb_r <= cb_r;
      ct_r <= top;
      cm_r <= mid;
      cb_r <= bot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ax_r <= gx_abs[ABS_W-1:0];
      ay_r <= gy_abs[ABS_W-1:0];
    end
    if (ctl.square) begin
      sq_x_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sq_y_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
    end
  end

  assign sq_x = sq_x_r;
  assign sq_y = sq_y_r;

endmodule

FILE: design/pem_root.sv
module pem_root import pem_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] sq_x,
  input  logic [SQ_W-1:0] sq_y,
  output root_res_t       res
);

  localparam int CMP_W = 2 * ROOT_W;

  logic [RAD_W-1:0]  rad;
  logic [CMP_W-1:0]  s_r;
  logic              sat_r;
  logic [ROOT_W-1:0] r_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [ROOT_W-1:0] trial;
  logic [CMP_W-1:0]  trial_sq;

  assign rad      = RAD_W'(sq_x) + RAD_W'(sq_y);
  assign trial    = r_r | (ROOT_W'(1) << step_r);
  assign trial_sq = CMP_W'(trial) * CMP_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // one result bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (start) begin
      s_r    <= rad[CMP_W-1:0];
      sat_r  <= |rad[RAD_W-1:CMP_W];
      r_r    <= '0;
      step_r <= STEP_W'(ROOT_W - 1);
    end else if (busy_r) begin
      if (trial_sq <= s_r) begin
        r_r <= trial;
      end
      step_r <= step_r - 1'b1;
    end
  end

  assign res.done  = done_r;
  assign res.value = sat_r ? EDGE_MAX : r_r;

endmodule

FILE: design/prewitt_edge_magnitude_unit.sv
// Prewitt 3x3 edge magnitude over a raster stream of 8-bit grey pixels. Each
// pixel word updates one entry of a line store (both previous rows packed in one
// single-port-write RAM with registered read), so a pixel is taken in order:
// accept and address the store, then read-modify-write the entry and shift the
// window. A pixel at column >= 2 and row >= 2 also yields the magnitude of the
// pixel one up and one left: the gradients are squared, the root is started,
// the bit-serial square root runs its eight steps and then raises its done
// flag, and the result goes to the output register. Border pixels give no result
// word; out_tlast marks the result of the last pixel of the frame. The output
// register lets the next pixel in while a result waits. cfg_index 0 sets the
// image width (3..1024), 1 the height (3..4096); out-of-range values clamp.
// Write only while idle.
module prewitt_edge_magnitude_unit import pem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,   // [7:0] edge_value
  output logic                  out_tlast,   // frame_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_last;
  logic [ROW_W-1:0]    row_last;
  logic [COL_W-1:0]    addr_r;
  logic [PIX_W-1:0]    bot_r;
  logic                produce_r;
  logic                last_r;
  logic                out_valid_r;
  logic [ROOT_W-1:0]   out_edge_r;
  logic                out_last_r;

  logic                in_acc;
  logic                load_out;
  logic                root_start;
  grad_ctl_t           gctl;
  logic [2*PIX_W-1:0]  ram_rdata;
  logic [SQ_W-1:0]     sq_x, sq_y;
  root_res_t           root_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // last column / row index after clamping
  always_comb begin
    if (width_r < WIDTH_W'(3)) begin
      col_last = COL_W'(2);
    end else if (32'(width_r) > MAX_WIDTH) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(width_r - 1'b1);
    end
    if (height_r < HEIGHT_W'(3)) begin
      row_last = ROW_W'(2);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(height_r - 1'b1);
    end
  end

  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (col_r >= col_last) begin
      col_nxt = '0;
      row_nxt = (row_r >= row_last) ? '0 : row_r + 1'b1;
    end
  end

  assign in_acc   = in_tvalid && in_tready;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r    <= col_r;
      bot_r     <= in_tdata[PIX_W-1:0];
      produce_r <= (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
      last_r    <= (col_r >= col_last) && (row_r >= row_last);
    end
    if (load_out) begin
      out_edge_r <= root_res.value;
      out_last_r <= last_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    gctl         = '0;
    root_start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        gctl.shift = 1'b1;
        state_nxt  = produce_r ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        gctl.square = 1'b1;
        state_nxt   = ST_START;
      end
      ST_START: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_res.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // entry holds {row two above, row above}; written back as {row above, new pixel}
  pem_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * PIX_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (gctl.shift),
    .waddr (addr_r),
    .wdata ({ram_rdata[PIX_W-1:0], bot_r}),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  pem_grad u_grad (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (gctl),
    .top   (ram_rdata[2*PIX_W-1:PIX_W]),
    .mid   (ram_rdata[PIX_W-1:0]),
    .bot   (bot_r),
    .sq_x  (sq_x),
    .sq_y  (sq_y)
  );

  pem_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .sq_x  (sq_x),
    .sq_y  (sq_y),
    .res   (root_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_edge_r;
  assign out_tlast  = out_last_r;

endmodule
